// ----- sv/tcfp_pkg.sv -----
// Shared types and constants for the text command frame parser.
package tcfp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int PAYLOAD_W       = 32;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [3:0] {
    ST_CONT         = 4'd0,
    ST_DONE         = 4'd1,
    ST_BAD_TYPE     = 4'd2,
    ST_LONE_CR      = 4'd3,
    ST_UNKNOWN_TYPE = 4'd4,
    ST_BAD_HDR      = 4'd5,
    ST_BAD_LEN      = 4'd6,
    ST_NEEDLESS     = 4'd7,
    ST_PROTO        = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    MT_UNKNOWN = 3'd0,
    MT_PUT     = 3'd1,
    MT_GET     = 3'd2,
    MT_LIST    = 3'd3,
    MT_QUEUE   = 3'd4
  } msg_type_t;

  typedef enum logic [2:0] {
    BC_FRAME   = 3'd0,
    BC_TYPE    = 3'd1,
    BC_HDR     = 3'd2,
    BC_LEN     = 3'd3,
    BC_PAYLOAD = 3'd4
  } byte_class_t;

  // one classified byte, front to back
  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_space;
    logic       is_upper;
    logic       is_num;
    logic       is_hdr;
  } char_info_t;

endpackage

// ----- sv/text_command_frame_parser_core.sv -----
// Top level of the text command frame parser: front, queue and back joined.
// Path: a byte is written into the queue on its input transfer and is parsed
// from there into the result register when the back pops it.
// Throughput: one byte per cycle while results are taken; the parser state
// update, with its x10 add for the length line, is combinational. A full queue
// behind a held result drops in_ready until the cycle after it leaves.
// Reset (rst, synchronous, active high) empties the queue, drops out_valid
// and puts the parser in its start state with type unknown and length zero.
module text_command_frame_parser_core #(
  parameter int LENGTH_BITS = tcfp_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel: one raw byte per transfer
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  // output channel: one result per input byte
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     status,
  output logic [2:0]                     message_type,
  output logic [2:0]                     byte_class,
  output logic [tcfp_pkg::PAYLOAD_W-1:0] payload_length
);
  import tcfp_pkg::*;

  // front -> queue
  logic       q_push;
  logic       q_full;
  char_info_t q_din;
  // queue -> back
  logic       q_pop;
  logic       q_empty;
  char_info_t q_dout;

  // Front: takes a transfer whenever the queue has room and tags the byte
  // (CR, LF, blank, upper, digit, header char) so the back needs no byte-class compares.
  tcfp_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  // Two-entry queue lets the input keep flowing while a result waits.
  tcfp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Back: parser state machine; it pops a byte whenever the result register
  // is free or being drained in the same cycle.
  tcfp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .message_type   (message_type),
    .byte_class     (byte_class),
    .payload_length (payload_length)
  );

endmodule

// ----- sv/tcfp_front.sv -----
// Front end: accepts raw bytes and classifies them for the parser.
module tcfp_front (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    q_full,
  output logic                    q_push,
  output tcfp_pkg::char_info_t    q_din
);
  import tcfp_pkg::*;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7A;  // 'z'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  logic upper, lower, dig;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    upper = (data_byte >= CH_UA) && (data_byte <= CH_UZ);
    lower = (data_byte >= CH_LA) && (data_byte <= CH_LZ);
    dig   = (data_byte >= CH_0) && (data_byte <= CH_9);
    q_din.ch       = data_byte;
    q_din.digit    = data_byte[3:0];  // '0'..'9' carry their value in the low nibble
    q_din.is_cr    = (data_byte == CH_CR);
    q_din.is_lf    = (data_byte == CH_LF);
    q_din.is_space = (data_byte == CH_SP) || (data_byte == CH_TAB);
    q_din.is_upper = upper;
    q_din.is_num   = dig;
    q_din.is_hdr   = upper || lower || dig || (data_byte == CH_SEMI) ||
                     (data_byte == CH_UNDER) || (data_byte == CH_EQ);
  end

endmodule

// ----- sv/tcfp_queue.sv -----
// Short queue of classified bytes between front and back.
module tcfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tcfp_pkg::char_info_t din,
  output logic                 full,
  input  logic                 pop,
  output tcfp_pkg::char_info_t dout,
  output logic                 empty
);
  import tcfp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  char_info_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= din;
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

endmodule

// ----- sv/tcfp_back.sv -----
// Back end: frame parser state machine and result register.
module tcfp_back #(
  parameter int LENGTH_BITS = tcfp_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  tcfp_pkg::char_info_t           q_dout,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     status,
  output logic [2:0]                     message_type,
  output logic [2:0]                     byte_class,
  output logic [tcfp_pkg::PAYLOAD_W-1:0] payload_length
);
  import tcfp_pkg::*;

  localparam int ACC_EXT = LENGTH_BITS + 4;
  localparam int EXT_W   = (LENGTH_BITS > PAYLOAD_W) ? LENGTH_BITS : PAYLOAD_W;
  localparam logic [2:0]  LETTER_SAT = 3'd6;
  localparam logic [39:0] WORD_PUT   = 40'h0000505554;
  localparam logic [39:0] WORD_GET   = 40'h0000474554;
  localparam logic [39:0] WORD_LIST  = 40'h004C495354;
  localparam logic [39:0] WORD_QUEUE = 40'h5155455545;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_TYPE      = 4'd1,
    PH_TYPE_CR   = 4'd2,
    PH_HDR       = 4'd3,
    PH_HDR_CR    = 4'd4,
    PH_LEN_FIRST = 4'd5,
    PH_LEN       = 4'd6,
    PH_LEN_CR    = 4'd7,
    PH_DATA      = 4'd8
  } phase_t;

  phase_t                 phase, phase_next;
  logic [39:0]            letters, letters_next;
  logic [2:0]             letter_cnt, letter_cnt_next;
  msg_type_t              cur_type, cur_type_next;
  logic [LENGTH_BITS-1:0] acc, acc_next;
  logic [LENGTH_BITS-1:0] remain, remain_next;

  status_t                st;
  byte_class_t            cls;
  msg_type_t              matched;
  logic [ACC_EXT-1:0]     acc10;
  logic                   acc_ovf;
  logic [LENGTH_BITS-1:0] remain_dec;
  logic [EXT_W-1:0]       acc_wide;

  assign q_pop = !q_empty && (!out_valid || out_ready);

  // acc * 10 + digit, overflow if anything lands above LENGTH_BITS
  assign acc10   = (ACC_EXT'(acc) << 3) + (ACC_EXT'(acc) << 1) + ACC_EXT'(q_dout.digit);
  assign acc_ovf = |acc10[ACC_EXT-1:LENGTH_BITS];
  assign remain_dec = remain - 1'b1;
  assign acc_wide   = EXT_W'(acc_next);

  always_comb begin
    if (letter_cnt == 3'd3 && letters == WORD_PUT) begin
      matched = MT_PUT;
    end else if (letter_cnt == 3'd3 && letters == WORD_GET) begin
      matched = MT_GET;
    end else if (letter_cnt == 3'd4 && letters == WORD_LIST) begin
      matched = MT_LIST;
    end else if (letter_cnt == 3'd5 && letters == WORD_QUEUE) begin
      matched = MT_QUEUE;
    end else begin
      matched = MT_UNKNOWN;
    end
  end

  always_comb begin
    phase_next      = phase;
    letters_next    = letters;
    letter_cnt_next = letter_cnt;
    cur_type_next   = cur_type;
    acc_next        = acc;
    remain_next     = remain;
    st              = ST_CONT;
    cls             = BC_FRAME;
    unique case (phase)
      PH_TYPE: begin
        if (q_dout.is_cr) begin
          phase_next = PH_TYPE_CR;
        end else if (q_dout.is_upper) begin
          letters_next    = {letters[31:0], q_dout.ch};
          letter_cnt_next = (letter_cnt < LETTER_SAT) ? letter_cnt + 1'b1 : letter_cnt;
          cls             = BC_TYPE;
        end else begin
          st = ST_BAD_TYPE;
        end
      end
      PH_TYPE_CR: begin
        if (!q_dout.is_lf) begin
          st = ST_LONE_CR;
        end else if (matched == MT_UNKNOWN) begin
          st = ST_UNKNOWN_TYPE;
        end else begin
          cur_type_next = matched;
          phase_next    = PH_HDR;
        end
      end
      PH_HDR: begin
        if (q_dout.is_cr) begin
          phase_next = PH_HDR_CR;
        end else if (q_dout.is_hdr) begin
          cls = BC_HDR;
        end else begin
          st = ST_BAD_HDR;
        end
      end
      PH_HDR_CR: begin
        if (!q_dout.is_lf) begin
          st = ST_PROTO;
        end else if (cur_type == MT_PUT) begin
          phase_next = PH_LEN_FIRST;
        end else begin
          st = ST_DONE;
        end
      end
      PH_LEN_FIRST: begin
        if (q_dout.is_num) begin
          acc_next   = LENGTH_BITS'(q_dout.digit);
          phase_next = PH_LEN;
          cls        = BC_LEN;
        end else begin
          st = ST_BAD_LEN;
        end
      end
      PH_LEN: begin
        if (q_dout.is_cr) begin
          phase_next = PH_LEN_CR;
        end else if (q_dout.is_num && !acc_ovf) begin
          acc_next = acc10[LENGTH_BITS-1:0];
          cls      = BC_LEN;
        end else begin
          st = ST_BAD_LEN;
        end
      end
      PH_LEN_CR: begin
        if (!q_dout.is_lf) begin
          st = ST_LONE_CR;
        end else if (acc == '0) begin
          st = ST_BAD_LEN;
        end else begin
          remain_next = acc;
          phase_next  = PH_DATA;
        end
      end
      PH_DATA: begin
        cls         = BC_PAYLOAD;
        remain_next = remain_dec;
        if (remain_dec == '0) begin
          st = ST_DONE;
        end
      end
      default: begin
        phase_next = PH_START;
        if (q_dout.is_space) begin
          phase_next = PH_START;
        end else if (q_dout.is_upper) begin
          letters_next    = {32'h0, q_dout.ch};
          letter_cnt_next = 3'd1;
          phase_next      = PH_TYPE;
          cls             = BC_TYPE;
        end else begin
          st = ST_BAD_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      phase      <= PH_START;
      letters    <= '0;
      letter_cnt <= '0;
      cur_type   <= MT_UNKNOWN;
      acc        <= '0;
      remain     <= '0;
    end else begin
      if (out_valid && out_ready && !q_pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        out_valid      <= 1'b1;
        status         <= st;
        message_type   <= cur_type_next;
        byte_class     <= cls;
        payload_length <= acc_wide[PAYLOAD_W-1:0];
        if (st != ST_CONT) begin
          phase      <= PH_START;
          letters    <= '0;
          letter_cnt <= '0;
          cur_type   <= MT_UNKNOWN;
          acc        <= '0;
          remain     <= '0;
        end else begin
          phase      <= phase_next;
          letters    <= letters_next;
          letter_cnt <= letter_cnt_next;
          cur_type   <= cur_type_next;
          acc        <= acc_next;
          remain     <= remain_next;
        end
      end
    end
  end

  a_end_to_start: assert property (@(posedge clk) disable iff (rst)
    (q_pop && st != ST_CONT) |=> (phase == PH_START && cur_type == MT_UNKNOWN))
    else $error("frame end did not return to start");
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (remain != '0 && acc != '0))
    else $error("payload phase with zero count");
  a_type_known: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HDR || phase == PH_HDR_CR || phase == PH_LEN_FIRST) |->
    (cur_type != MT_UNKNOWN))
    else $error("header phase without a matched command");

endmodule
